[sv/mecpu_pkg.sv]
// Package for the microcoded 8-bit bus CPU step core.
// Holds control word bits, opcodes, action codes and the microcode table.
// No dependencies.
`default_nettype none

package mecpu_pkg;

    // Program memory geometry and microstep count per instruction
    localparam int MEM_DEPTH       = 16;
    localparam int MEM_AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int STEPS_PER_INSTR = 5;

    typedef logic [7:0]  t_byte;
    typedef logic [2:0]  t_step;
    typedef logic [3:0]  t_opcode;
    typedef logic [14:0] t_ctrl;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Opcodes (high nibble of the instruction register)
    localparam t_opcode OP_HLT = 4'd0;
    localparam t_opcode OP_LDA = 4'd1;
    localparam t_opcode OP_STA = 4'd2;
    localparam t_opcode OP_ADD = 4'd3;

    // Microstep numbers
    localparam t_step STEP_FETCH_ADDR = 3'd0;
    localparam t_step STEP_FETCH_INSTR = 3'd1;
    localparam t_step STEP_EXEC_0     = 3'd2;
    localparam t_step STEP_EXEC_1     = 3'd3;
    localparam t_step STEP_EXEC_2     = 3'd4;

    // Control word bits
    localparam t_ctrl SIG_CI  = 15'h0001;
    localparam t_ctrl SIG_CO  = 15'h0002;
    localparam t_ctrl SIG_CE  = 15'h0004;
    localparam t_ctrl SIG_BO  = 15'h0008;
    localparam t_ctrl SIG_BI  = 15'h0010;
    localparam t_ctrl SIG_SUB = 15'h0020;
    localparam t_ctrl SIG_SO  = 15'h0040;
    localparam t_ctrl SIG_AO  = 15'h0080;
    localparam t_ctrl SIG_AI  = 15'h0100;
    localparam t_ctrl SIG_II  = 15'h0200;
    localparam t_ctrl SIG_IO  = 15'h0400;
    localparam t_ctrl SIG_RO  = 15'h0800;
    localparam t_ctrl SIG_RI  = 15'h1000;
    localparam t_ctrl SIG_MI  = 15'h2000;
    localparam t_ctrl SIG_HLT = 15'h4000;

    // Look up the control word for one opcode and microstep
    function automatic t_ctrl microcode(input t_opcode opcode, input t_step step);
        t_ctrl cw;
        cw = '0;
        if (step == STEP_FETCH_ADDR) begin
            cw = SIG_CO | SIG_MI;
        end else if (step == STEP_FETCH_INSTR) begin
            cw = SIG_RO | SIG_II | SIG_CE;
        end else begin
            unique case (opcode)
                OP_HLT: begin
                    if (step == STEP_EXEC_0) cw = SIG_HLT;
                end
                OP_LDA: begin
                    if (step == STEP_EXEC_0)      cw = SIG_IO | SIG_MI;
                    else if (step == STEP_EXEC_1) cw = SIG_RO | SIG_AI;
                end
                OP_STA: begin
                    if (step == STEP_EXEC_0)      cw = SIG_IO | SIG_MI;
                    else if (step == STEP_EXEC_1) cw = SIG_AO | SIG_RI;
                end
                OP_ADD: begin
                    if (step == STEP_EXEC_0)      cw = SIG_IO | SIG_MI;
                    else if (step == STEP_EXEC_1) cw = SIG_RO | SIG_BI;
                    else if (step == STEP_EXEC_2) cw = SIG_SO | SIG_AI;
                end
                default: cw = '0;
            endcase
        end
        return cw;
    endfunction

endpackage

`default_nettype wire

[sv/microcoded_eight_bit_cpu_step_core.sv]
// Top level of the microcoded 8-bit bus CPU step core.
// Runs one microstep, program byte write or memory clear per request; ACT_NONE does nothing.
// Depends on mecpu_pkg.
//
//  Channel  Handshake                    Payload
//  -------  ---------------------------  -------------------------------------------
//  input    i_in_valid  / o_in_stall     i_action, i_mem_address, i_data_byte
//  output   o_out_valid / i_out_stall    o_bus_value .. o_halted (CPU state after step)
//
// The microcode lookup, bus mux and register loads are combinational and sit
// between the architectural registers, which also serve as the result register.
// A new request is taken every cycle unless a result waits under i_out_stall.
// Reset (i_rst_n low, synchronous) clears all registers and the memory valid bits,
// so the whole program memory reads as zero after reset.
// A clear request drops all memory valid bits at once.
`default_nettype none

module microcoded_eight_bit_cpu_step_core
    import mecpu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_mem_address,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_bus_value,
    output logic [7:0]       o_program_counter,
    output logic [7:0]       o_accumulator_a,
    output logic [7:0]       o_operand_b,
    output logic [7:0]       o_instruction_word,
    output logic [7:0]       o_address_latch,
    output logic [2:0]       o_micro_step,
    output logic [14:0]      o_next_control,
    output logic             o_halted
);

    // Architectural state
    t_byte r_a, n_a;
    t_byte r_b, n_b;
    t_byte r_mar, n_mar;
    t_byte r_ir, n_ir;
    t_byte r_pc, n_pc;
    t_byte r_bus, n_bus;
    t_step r_step, n_step;
    logic  r_halt, n_halt;
    logic  r_out_valid, n_out_valid;

    // Program memory with per-entry valid bits
    t_byte                 r_mem   [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_mem_vld;

    logic              accept;
    t_action           act;
    t_ctrl             cw;
    t_byte             mem_rd;
    logic              mar_in_range;
    logic [MEM_AW-1:0] mar_idx;
    logic [7:0]        wr_addr_ext;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_idx;
    t_byte             wr_data;
    logic              clr_en;

    // Handshake: stall input only while a result waits downstream
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign act        = t_action'(i_action);

    // Current control word and memory read at the address register
    assign cw           = microcode(r_ir[7:4], r_step);
    assign mar_in_range = ({1'b0, r_mar} < 9'(MEM_DEPTH));
    assign mar_idx      = r_mar[MEM_AW-1:0];
    assign mem_rd       = (mar_in_range && r_mem_vld[mar_idx]) ? r_mem[mar_idx] : 8'h00;
    assign wr_addr_ext  = 8'(i_mem_address);

    // Compute the next state for one request
    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_mar   = r_mar;
        n_ir    = r_ir;
        n_pc    = r_pc;
        n_bus   = r_bus;
        n_step  = r_step;
        n_halt  = r_halt;
        wr_en   = 1'b0;
        wr_idx  = wr_addr_ext[MEM_AW-1:0];
        wr_data = i_data_byte;
        clr_en  = 1'b0;
        if (accept) begin
            unique case (act)
                ACT_TICK: begin
                    if (!r_halt) begin
                        if ((cw & SIG_HLT) != '0) n_halt = 1'b1;
                        // First active bus source in this list wins
                        priority if ((cw & SIG_CO) != '0)  n_bus = r_pc;
                        else if ((cw & SIG_AO) != '0)      n_bus = r_a;
                        else if ((cw & SIG_SO) != '0)      n_bus = r_a + r_b;
                        else if ((cw & SIG_SUB) != '0)     n_bus = r_a - r_b;
                        else if ((cw & SIG_BO) != '0)      n_bus = r_b;
                        else if ((cw & SIG_IO) != '0)      n_bus = {4'h0, r_ir[3:0]};
                        else if ((cw & SIG_RO) != '0)      n_bus = mem_rd;
                        else                               n_bus = r_bus;
                        // Loads from the bus
                        if ((cw & SIG_RI) != '0 && mar_in_range) begin
                            wr_en   = 1'b1;
                            wr_idx  = mar_idx;
                            wr_data = n_bus;
                        end
                        if ((cw & SIG_MI) != '0) n_mar = n_bus;
                        if ((cw & SIG_II) != '0) n_ir  = n_bus;
                        if ((cw & SIG_BI) != '0) n_b   = n_bus;
                        if ((cw & SIG_AI) != '0) n_a   = n_bus;
                        if ((cw & SIG_CI) != '0) n_pc  = n_bus;
                        if ((cw & SIG_CE) != '0) n_pc  = r_pc + 8'd1;
                        // Advance the microstep counter
                        n_step = (r_step == 3'(STEPS_PER_INSTR - 1)) ? '0 : r_step + 3'd1;
                    end
                end
                ACT_WRITE: begin
                    wr_en = (wr_addr_ext < 8'(MEM_DEPTH)) || (MEM_DEPTH > 255);
                end
                ACT_CLEAR: begin
                    clr_en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Raise result valid on accept, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept)                         n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
    end

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_mar       <= '0;
            r_ir        <= '0;
            r_pc        <= '0;
            r_bus       <= '0;
            r_step      <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a         <= n_a;
            r_b         <= n_b;
            r_mar       <= n_mar;
            r_ir        <= n_ir;
            r_pc        <= n_pc;
            r_bus       <= n_bus;
            r_step      <= n_step;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    // Write memory data
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_idx] <= wr_data;
    end

    // Track written entries; drop all on clear or reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (clr_en) begin
            r_mem_vld <= '0;
        end else if (wr_en) begin
            r_mem_vld[wr_idx] <= 1'b1;
        end
    end

    // Drive result fields from the state registers
    assign o_out_valid        = r_out_valid;
    assign o_bus_value        = r_bus;
    assign o_program_counter  = r_pc;
    assign o_accumulator_a    = r_a;
    assign o_operand_b        = r_b;
    assign o_instruction_word = r_ir;
    assign o_address_latch    = r_mar;
    assign o_micro_step       = r_step;
    assign o_next_control     = microcode(r_ir[7:4], r_step);
    assign o_halted           = r_halt;

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped without reset");

    // Microstep counter stays inside the instruction length
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < 3'(STEPS_PER_INSTR))
        else $error("microstep counter out of range");

    // A tick while halted changes no CPU register
    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && act == ACT_TICK && r_halt) |=>
            ($stable(r_pc) && $stable(r_a) && $stable(r_b) && $stable(r_bus)
             && $stable(r_step) && $stable(r_ir) && $stable(r_mar)))
        else $error("state changed on a halted tick");

    // Non-tick requests leave the microstep counter alone
    a_step_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && act != ACT_TICK) |=> $stable(r_step))
        else $error("microstep advanced without a tick");

    // No input is taken while a result is held under stall
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !accept)
        else $error("request accepted over a stalled result");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for microcoded_eight_bit_cpu_step_core.
// Runs directed and random programs through the CPU and checks every step result
// against an in-bench model of the microcode sequencer. Depends on mecpu_pkg.
module tb_top
    import mecpu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_action      act;
        logic [3:0]   adr;
        t_byte        dat;
        bit           hold_off;   // wait for every result before presenting this request
    } t_cpu_req;

    typedef struct {
        t_byte bus;
        t_byte pc;
        t_byte a;
        t_byte b;
        t_byte ir;
        t_byte mar;
        t_step stp;
        t_ctrl ctrl;
        logic  halt;
    } t_cpu_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_action = '0;
    logic [3:0]  i_mem_address = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_bus_value;
    logic [7:0]  o_program_counter;
    logic [7:0]  o_accumulator_a;
    logic [7:0]  o_operand_b;
    logic [7:0]  o_instruction_word;
    logic [7:0]  o_address_latch;
    logic [2:0]  o_micro_step;
    logic [14:0] o_next_control;
    logic        o_halted;

    microcoded_eight_bit_cpu_step_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_mem_address      (i_mem_address),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_bus_value        (o_bus_value),
        .o_program_counter  (o_program_counter),
        .o_accumulator_a    (o_accumulator_a),
        .o_operand_b        (o_operand_b),
        .o_instruction_word (o_instruction_word),
        .o_address_latch    (o_address_latch),
        .o_micro_step       (o_micro_step),
        .o_next_control     (o_next_control),
        .o_halted           (o_halted)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cpu_req  request_q[$];
    t_cpu_view cpu_state_q[$];
    t_cpu_req  cur_req;
    bit        req_taken = 1'b0;
    int        n_sent = 0;
    int        n_total = 1;
    int        n_err = 0;

    // Model state
    t_byte cpu_a, cpu_b, cpu_mar, cpu_ir, cpu_pc, cpu_bus;
    t_step cpu_step;
    logic  cpu_halt;
    t_byte cpu_mem [MEM_DEPTH];

    // Control word for one opcode and microstep
    function automatic t_ctrl control_word(input t_opcode op, input t_step st);
        t_ctrl w;
        w = '0;
        case (st)
            STEP_FETCH_ADDR:  w = SIG_CO | SIG_MI;
            STEP_FETCH_INSTR: w = SIG_RO | SIG_II | SIG_CE;
            STEP_EXEC_0: begin
                if (op == OP_HLT) w = SIG_HLT;
                else if (op == OP_LDA || op == OP_STA || op == OP_ADD) w = SIG_IO | SIG_MI;
            end
            STEP_EXEC_1: begin
                if (op == OP_LDA)      w = SIG_RO | SIG_AI;
                else if (op == OP_STA) w = SIG_AO | SIG_RI;
                else if (op == OP_ADD) w = SIG_RO | SIG_BI;
            end
            STEP_EXEC_2: begin
                if (op == OP_ADD) w = SIG_SO | SIG_AI;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // Apply one request to the model and return the visible CPU state after it
    function automatic t_cpu_view next_cpu_state(input t_cpu_req rq);
        t_cpu_view v;
        t_ctrl     cw;
        t_byte     bus;
        case (rq.act)
            ACT_TICK: begin
                if (!cpu_halt) begin
                    cw  = control_word(cpu_ir[7:4], cpu_step);
                    bus = cpu_bus;
                    if (cw & SIG_HLT) cpu_halt = 1'b1;
                    // bus sources: the last active one wins
                    if (cw & SIG_RO)  bus = (cpu_mar < MEM_DEPTH) ? cpu_mem[cpu_mar] : '0;
                    if (cw & SIG_IO)  bus = {4'h0, cpu_ir[3:0]};
                    if (cw & SIG_BO)  bus = cpu_b;
                    if (cw & SIG_SUB) bus = cpu_a - cpu_b;
                    if (cw & SIG_SO)  bus = cpu_a + cpu_b;
                    if (cw & SIG_AO)  bus = cpu_a;
                    if (cw & SIG_CO)  bus = cpu_pc;
                    // register loads
                    if ((cw & SIG_RI) && cpu_mar < MEM_DEPTH) cpu_mem[cpu_mar] = bus;
                    if (cw & SIG_MI) cpu_mar = bus;
                    if (cw & SIG_II) cpu_ir = bus;
                    if (cw & SIG_BI) cpu_b = bus;
                    if (cw & SIG_AI) cpu_a = bus;
                    if (cw & SIG_CI) cpu_pc = bus;
                    if (cw & SIG_CE) cpu_pc = cpu_pc + 8'd1;
                    cpu_bus  = bus;
                    cpu_step = (cpu_step == STEPS_PER_INSTR - 1) ? '0 : cpu_step + 3'd1;
                end
            end
            ACT_WRITE: cpu_mem[rq.adr] = rq.dat;
            ACT_CLEAR: begin
                foreach (cpu_mem[i]) cpu_mem[i] = '0;
            end
            default: ;
        endcase
        v.bus  = cpu_bus;
        v.pc   = cpu_pc;
        v.a    = cpu_a;
        v.b    = cpu_b;
        v.ir   = cpu_ir;
        v.mar  = cpu_mar;
        v.stp  = cpu_step;
        v.ctrl = control_word(cpu_ir[7:4], cpu_step);
        v.halt = cpu_halt;
        return v;
    endfunction

    // Print one mismatch line and count it
    task automatic report(input string what, input int unsigned got, input int unsigned want);
        n_err++;
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Queue one request; mark a hold-off once every 300 requests
    task automatic push_req(input t_action act, input logic [3:0] adr, input t_byte dat);
        t_cpu_req rq;
        rq.act      = act;
        rq.adr      = adr;
        rq.dat      = dat;
        rq.hold_off = (request_q.size() % 300 == 150);
        request_q.push_back(rq);
    endtask

    task automatic push_tick();
        push_req(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    endtask

    // Memory traffic between program steps: writes, clears and ignored codes
    task automatic push_noise();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            push_req(ACT_WRITE, 4'($urandom_range(15)), 8'($urandom_range(255)));
        else if (r < 82)
            push_req(ACT_CLEAR, 4'($urandom_range(15)), 8'($urandom_range(255)));
        else
            push_req(ACT_NONE, 4'($urandom_range(15)), 8'($urandom_range(255)));
    endtask

    // Accept requests and predict their results
    always @(posedge i_clk) begin : take_requests
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            cpu_state_q.push_back(next_cpu_state(cur_req));
            req_taken = 1'b1;
        end
    end

    // Present requests and receiver stalls at the falling edge
    always @(negedge i_clk) begin : drive_requests
        int phase;
        int idle_pct;
        int stall_pct;
        if (i_rst_n) begin
            phase = (n_sent * 4) / n_total;
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            i_out_stall <= ($urandom_range(99) < stall_pct);
            // hold a stalled request; otherwise advance
            if (!i_in_valid || req_taken) begin
                req_taken = 1'b0;
                if (request_q.size() == 0
                        || (request_q[0].hold_off && cpu_state_q.size() != 0)
                        || $urandom_range(99) < idle_pct) begin
                    i_in_valid <= 1'b0;
                end else begin
                    cur_req = request_q.pop_front();
                    n_sent++;
                    i_in_valid    <= 1'b1;
                    i_action      <= cur_req.act;
                    i_mem_address <= cur_req.adr;
                    i_data_byte   <= cur_req.dat;
                end
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_cpu_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cpu_state_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                want = cpu_state_q.pop_front();
                if (o_bus_value !== want.bus)         report("bus_value", o_bus_value, want.bus);
                if (o_program_counter !== want.pc)    report("program_counter", o_program_counter, want.pc);
                if (o_accumulator_a !== want.a)       report("accumulator_a", o_accumulator_a, want.a);
                if (o_operand_b !== want.b)           report("operand_b", o_operand_b, want.b);
                if (o_instruction_word !== want.ir)   report("instruction_word", o_instruction_word, want.ir);
                if (o_address_latch !== want.mar)     report("address_latch", o_address_latch, want.mar);
                if (o_micro_step !== want.stp)        report("micro_step", o_micro_step, want.stp);
                if (o_next_control !== want.ctrl)     report("next_control", o_next_control, want.ctrl);
                if (o_halted !== want.halt)           report("halted", o_halted, want.halt);
            end
        end
    end

    // Build the stimulus, run it and decide the outcome
    initial begin : run_test
        int     r;
        t_opcode op;
        cpu_a = '0; cpu_b = '0; cpu_mar = '0; cpu_ir = '0; cpu_pc = '0; cpu_bus = '0;
        cpu_step = '0;
        cpu_halt = 1'b0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;

        // Directed: ignored code, clear, field extremes, then LDA / ADD with wrap / STA
        push_req(ACT_NONE, 4'hF, 8'hFF);
        push_req(ACT_WRITE, 4'hF, 8'hFF);
        push_req(ACT_CLEAR, 4'h0, 8'h00);
        push_req(ACT_WRITE, 4'hF, 8'hFF);
        push_req(ACT_WRITE, 4'hE, 8'h01);
        push_req(ACT_WRITE, 4'h0, {OP_LDA, 4'hF});
        push_req(ACT_WRITE, 4'h1, {OP_ADD, 4'hE});
        push_req(ACT_WRITE, 4'h2, {OP_STA, 4'h0});
        for (int i = 0; i < 3 * STEPS_PER_INSTR; i++)
            push_req(ACT_TICK, (i % 2) ? 4'hF : 4'h0, (i % 2) ? 8'hFF : 8'h00);

        // Random programs: one instruction per slot, memory traffic in between.
        // Slot 16 fetches past the end of memory, reads zero and halts.
        for (int k = 3; k <= MEM_DEPTH; k++) begin
            repeat ($urandom_range(85, 45)) push_noise();
            if (k < MEM_DEPTH) begin
                r = $urandom_range(99);
                if (r < 27)      op = OP_LDA;
                else if (r < 54) op = OP_STA;
                else if (r < 81) op = OP_ADD;
                else             op = t_opcode'($urandom_range(15, OP_ADD + 1));
                push_req(ACT_WRITE, 4'(k), {op, 4'($urandom_range(15))});
            end
            // no traffic between the fetch steps, so the fetched word stays put
            push_tick();
            push_tick();
            for (int s = 2; s < STEPS_PER_INSTR; s++) begin
                if ($urandom_range(3) == 0) push_noise();
                push_tick();
            end
        end

        // Halted: ticks do nothing, memory requests still land
        repeat (250) begin
            if ($urandom_range(1)) push_tick();
            else push_noise();
        end
        n_total = request_q.size();

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain stimulus, then results
        while (request_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (cpu_state_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
